// ===== src/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Thread state and result codes, table entry layout, field widths.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // default number of thread slots
  localparam int THREAD_COUNT_DEF = 8;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int DLY_W    = 16;
  localparam int TID_W    = 4;
  localparam int PERIOD_W = 10;
  localparam int STAT_W   = 3;
  localparam int ID_W     = 3;
  localparam int NR_W     = 4;

  // thread slot states
  typedef enum logic [STAT_W-1:0] {
    ST_UNUSED    = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_READY     = 3'd2,
    ST_BLOCKED   = 3'd3,
    ST_SUSPENDED = 3'd4
  } thr_st_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    RS_DONE     = 3'd0,
    RS_SWITCHED = 3'd1,
    RS_NONE     = 3'd2,
    RS_FULL     = 3'd3,
    RS_IGNORED  = 3'd4
  } res_t;

  // event kinds
  localparam logic [KIND_W-1:0] K_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] K_YIELD   = 3'd1;
  localparam logic [KIND_W-1:0] K_CREATE  = 3'd2;
  localparam logic [KIND_W-1:0] K_STOP    = 3'd3;
  localparam logic [KIND_W-1:0] K_DELAY   = 3'd4;
  localparam logic [KIND_W-1:0] K_SUSPEND = 3'd5;
  localparam logic [KIND_W-1:0] K_RESUME  = 3'd6;

  // one slot of the thread table
  typedef struct packed {
    thr_st_t          st;
    logic [DLY_W-1:0] dly;
  } entry_t;

  // table write enables
  typedef struct packed {
    logic stat_we;
    logic dly_we;
  } tbl_we_t;

endpackage

// ===== src/round_robin_thread_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core: hardware thread table and scheduler
// Takes scheduler events, updates the thread table held in memory and
// returns one result request per event.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------------
//   in_     | in  | in_valid / in_stall   | kind, delay_ms, target_id
//   out_    | out | out_valid / out_stall | status, running_id, not_ready_count,
//           |     |                       | created_id
//   apb     | in  | psel/penable/pready   | tick_period_ms @0, preemptive_mode @4
//
// A scheduling event sweeps the table one slot a cycle through the memory read
// port, then the S_CUR and S_NEW states write the switch and S_FIN hands the
// result over; the next request is taken only once the sequencer is back in
// S_IDLE. A failed search skips S_NEW; create and resume skip S_CUR and S_NEW.
// Delay events first run the 16-step divider. Stop of thread 0, zero delay and
// unknown kinds go straight to S_FIN.
// Reset is synchronous; the valid bits of the table clear at once, so no
// clearing pass follows reset. A result not yet taken holds the sequencer in
// its last state; once handed over it waits while the next event is taken.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core #(
  parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrts_pkg::KIND_W-1:0]   in_kind,
  input  logic [rrts_pkg::DLY_W-1:0]    in_delay_ms,
  input  logic [rrts_pkg::TID_W-1:0]    in_target_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrts_pkg::STAT_W-1:0]   out_status,
  output logic [rrts_pkg::ID_W-1:0]     out_running_id,
  output logic [rrts_pkg::NR_W-1:0]     out_not_ready_count,
  output logic [rrts_pkg::ID_W-1:0]     out_created_id,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IW     = $clog2(THREAD_COUNT);
  localparam int CW     = $clog2(THREAD_COUNT + 1);
  localparam int ID_W   = rrts_pkg::ID_W;
  localparam int NR_W   = rrts_pkg::NR_W;
  localparam int TID_W  = rrts_pkg::TID_W;
  localparam int DLY_W  = rrts_pkg::DLY_W;
  localparam int PW     = rrts_pkg::PERIOD_W;

  localparam logic [CW-1:0] N_C    = CW'(THREAD_COUNT);
  localparam logic [IW-1:0] LAST_C = IW'(THREAD_COUNT - 1);

  // register indexes, selected by paddr[2]
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_PREEMPT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SWEEP,
    S_CUR,
    S_NEW,
    S_FIN
  } state_t;

  // configuration registers
  logic [PW-1:0] period_r;
  logic          preempt_r;

  // sequencer state
  state_t                state_r;
  logic [rrts_pkg::KIND_W-1:0] kind_r;
  logic [TID_W-1:0]      tid_r;
  logic [DLY_W-1:0]      ticks_r;
  logic [IW-1:0]         cur_r;
  logic                  sched_r;
  logic                  cnt_en_r;
  logic [CW-1:0]         iss_r;
  logic                  proc_vld_r;
  logic [IW-1:0]         proc_idx_r;

  // sweep trackers
  logic                  taken_r;
  logic [IW-1:0]         created_r;
  logic                  resumed_r;
  rrts_pkg::thr_st_t     cur_st_r;
  logic                  hi_fnd_r;
  logic [IW-1:0]         hi_idx_r;
  logic                  lo_fnd_r;
  logic [IW-1:0]         lo_idx_r;
  logic [CW-1:0]         nr_r;
  rrts_pkg::res_t        res_st_r;

  // output register
  logic                  out_valid_r;
  rrts_pkg::res_t        out_status_r;
  logic [ID_W-1:0]       out_run_r;
  logic [NR_W-1:0]       out_nr_r;
  logic [ID_W-1:0]       out_crt_r;

  // table and divider connections
  logic                  rd_en;
  logic [IW-1:0]         raddr;
  rrts_pkg::entry_t      rd_ent;
  rrts_pkg::tbl_we_t     tbl_we;
  logic [IW-1:0]         waddr;
  rrts_pkg::entry_t      wdata;
  logic                  div_start;
  logic                  div_done;
  logic [DLY_W-1:0]      div_q;

  // per-slot update
  rrts_pkg::entry_t      upd;
  logic                  is_cur;
  logic                  hit_create;
  logic                  hit_resume;
  logic [DLY_W-1:0]      dly_dec;
  logic [IW+TID_W-1:0]   tid_ext;
  logic [IW+TID_W-1:0]   idx_ext;

  // event decode
  logic                  dec_sched;
  logic                  dec_cnt;
  state_t                dec_next;

  logic                  in_acc;
  logic                  out_free;
  logic                  cfg_wr;
  logic                  found;
  logic [IW-1:0]         next_idx;
  logic [IW+ID_W-1:0]    run_ext;
  logic [IW+ID_W-1:0]    crt_ext;
  logic [CW+NR_W-1:0]    nr_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign found    = hi_fnd_r || lo_fnd_r;
  assign next_idx = hi_fnd_r ? hi_idx_r : lo_idx_r;

  assign div_start = in_acc && (in_kind == rrts_pkg::K_DELAY) && (in_delay_ms != '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PW'(10);
      preempt_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PERIOD:  period_r  <= pwdata[PW-1:0];
        REG_PREEMPT: preempt_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PERIOD:  prdata = {{(32-PW){1'b0}}, period_r};
      REG_PREEMPT: prdata = {31'b0, preempt_r};
      default:     prdata = '0;
    endcase
  end

  rrts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_delay_ms),
    .divisor  (period_r),
    .done     (div_done),
    .quot     (div_q)
  );

  rrts_table #(
    .THREAD_COUNT (THREAD_COUNT)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .raddr  (raddr),
    .rd_ent (rd_ent),
    .we     (tbl_we),
    .waddr  (waddr),
    .wdata  (wdata)
  );

  // event decode: schedule, count down, first state
  always_comb begin
    dec_sched = 1'b1;
    dec_cnt   = !preempt_r;
    dec_next  = S_SWEEP;
    unique case (in_kind) inside
      rrts_pkg::K_TICK:    dec_cnt = 1'b1;
      rrts_pkg::K_YIELD,
      rrts_pkg::K_SUSPEND: ;
      rrts_pkg::K_CREATE,
      rrts_pkg::K_RESUME: begin
        dec_sched = 1'b0;
        dec_cnt   = 1'b0;
      end
      rrts_pkg::K_STOP: begin
        if (cur_r == '0) dec_next = S_FIN;
      end
      rrts_pkg::K_DELAY: begin
        dec_next = (in_delay_ms == '0) ? S_FIN : S_DIV;
      end
      default: dec_next = S_FIN;
    endcase
  end

  // slot update: event action, then countdown
  always_comb begin
    upd        = rd_ent;
    is_cur     = (proc_idx_r == cur_r);
    hit_create = 1'b0;
    hit_resume = 1'b0;
    tid_ext    = {{IW{1'b0}}, tid_r};
    idx_ext    = {{TID_W{1'b0}}, proc_idx_r};
    dly_dec    = rd_ent.dly - DLY_W'(1);

    if (is_cur) begin
      case (kind_r)
        rrts_pkg::K_STOP:    upd.st = rrts_pkg::ST_UNUSED;
        rrts_pkg::K_DELAY: begin
          upd.st  = rrts_pkg::ST_BLOCKED;
          upd.dly = ticks_r;
        end
        rrts_pkg::K_SUSPEND: upd.st = rrts_pkg::ST_SUSPENDED;
        default: ;
      endcase
    end

    // lowest unused slot is claimed by create
    if (kind_r == rrts_pkg::K_CREATE && !taken_r && upd.st == rrts_pkg::ST_UNUSED) begin
      upd.st     = rrts_pkg::ST_READY;
      upd.dly    = '0;
      hit_create = 1'b1;
    end

    if (kind_r == rrts_pkg::K_RESUME && tid_ext == idx_ext &&
        upd.st == rrts_pkg::ST_SUSPENDED) begin
      upd.st     = rrts_pkg::ST_READY;
      hit_resume = 1'b1;
    end

    // delay countdown of blocked slots
    dly_dec = upd.dly - DLY_W'(1);
    if (cnt_en_r && upd.st == rrts_pkg::ST_BLOCKED && upd.dly != '0) begin
      upd.dly = dly_dec;
      if (dly_dec == '0) upd.st = rrts_pkg::ST_READY;
    end
  end

  // table port control
  always_comb begin
    rd_en          = (state_r == S_SWEEP) && (iss_r != N_C);
    raddr          = iss_r[IW-1:0];
    tbl_we.stat_we = 1'b0;
    tbl_we.dly_we  = 1'b0;
    waddr          = proc_idx_r;
    wdata          = upd;
    unique case (state_r)
      S_SWEEP: begin
        tbl_we.stat_we = proc_vld_r;
        tbl_we.dly_we  = proc_vld_r;
      end
      S_CUR: begin
        // running thread gives way
        tbl_we.stat_we = found && (cur_st_r == rrts_pkg::ST_RUNNING);
        waddr          = cur_r;
        wdata.st       = rrts_pkg::ST_READY;
      end
      S_NEW: begin
        tbl_we.stat_we = 1'b1;
        waddr          = next_idx;
        wdata.st       = rrts_pkg::ST_RUNNING;
      end
      default: ;
    endcase
  end

  // ids and count masked to the result field widths
  assign run_ext = {{ID_W{1'b0}}, cur_r};
  assign crt_ext = {{ID_W{1'b0}}, created_r};
  assign nr_ext  = {{NR_W{1'b0}}, nr_r};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r     <= in_kind;
            tid_r      <= in_target_id;
            iss_r      <= '0;
            proc_vld_r <= 1'b0;
            taken_r    <= 1'b0;
            created_r  <= '0;
            resumed_r  <= 1'b0;
            hi_fnd_r   <= 1'b0;
            lo_fnd_r   <= 1'b0;
            nr_r       <= '0;
            res_st_r   <= rrts_pkg::RS_IGNORED;
            sched_r    <= dec_sched;
            cnt_en_r   <= dec_cnt;
            state_r    <= dec_next;
          end
        end

        S_DIV: begin
          if (div_done) begin
            ticks_r <= (div_q == '0) ? DLY_W'(1) : div_q;
            state_r <= S_SWEEP;
          end
        end

        S_SWEEP: begin
          // read issue, one slot a cycle
          proc_vld_r <= rd_en;
          proc_idx_r <= raddr;
          if (rd_en) iss_r <= iss_r + CW'(1);

          // slot returned by the memory
          if (proc_vld_r) begin
            if (is_cur) cur_st_r <= upd.st;
            if (upd.st == rrts_pkg::ST_READY && !is_cur) begin
              if (proc_idx_r > cur_r && !hi_fnd_r) begin
                hi_fnd_r <= 1'b1;
                hi_idx_r <= proc_idx_r;
              end
              if (proc_idx_r < cur_r && !lo_fnd_r) begin
                lo_fnd_r <= 1'b1;
                lo_idx_r <= proc_idx_r;
              end
            end
            if (sched_r && (upd.st == rrts_pkg::ST_BLOCKED ||
                            upd.st == rrts_pkg::ST_SUSPENDED)) begin
              nr_r <= nr_r + CW'(1);
            end
            if (hit_create) begin
              taken_r   <= 1'b1;
              created_r <= proc_idx_r;
            end
            if (hit_resume) resumed_r <= 1'b1;

            // last slot: issue has already stopped
            if (proc_idx_r == LAST_C) begin
              if (sched_r) begin
                state_r <= S_CUR;
              end else begin
                state_r <= S_FIN;
                if (kind_r == rrts_pkg::K_CREATE) begin
                  res_st_r <= (taken_r || hit_create) ? rrts_pkg::RS_DONE
                                                      : rrts_pkg::RS_FULL;
                end else begin
                  res_st_r <= (resumed_r || hit_resume) ? rrts_pkg::RS_DONE
                                                        : rrts_pkg::RS_IGNORED;
                end
              end
            end
          end
        end

        S_CUR: begin
          if (found) begin
            nr_r    <= '0;
            state_r <= S_NEW;
          end else begin
            res_st_r <= rrts_pkg::RS_NONE;
            state_r  <= S_FIN;
          end
        end

        S_NEW: begin
          cur_r    <= next_idx;
          res_st_r <= rrts_pkg::RS_SWITCHED;
          state_r  <= S_FIN;
        end

        S_FIN: begin
          // hand over once the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_run_r    <= run_ext[ID_W-1:0];
            out_nr_r     <= nr_ext[NR_W-1:0];
            out_crt_r    <= crt_ext[ID_W-1:0];
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_running_id      = out_run_r;
  assign out_not_ready_count = out_nr_r;
  assign out_created_id      = out_crt_r;

endmodule

// ===== src/rrts_div.sv =====
// ----------------------------------------------------------------------------
// rrts_div: iterative delay divider
// Restoring division of a 16-bit millisecond count by the 10-bit tick period,
// one quotient bit per cycle. A zero divisor is taken as one.
// ----------------------------------------------------------------------------
module rrts_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rrts_pkg::DLY_W-1:0]    dividend,
  input  logic [rrts_pkg::PERIOD_W-1:0] divisor,
  output logic                         done,
  output logic [rrts_pkg::DLY_W-1:0]    quot
);

  localparam int CNT_W = $clog2(rrts_pkg::DLY_W);
  localparam int PW    = rrts_pkg::PERIOD_W;

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [PW-1:0]                rem_r;
  logic [PW-1:0]                dvs_r;
  logic [rrts_pkg::DLY_W-1:0]   quo_r;
  logic [PW:0]                  rem_sh;
  logic [PW:0]                  rem_sub;
  logic                         ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, quo_r[rrts_pkg::DLY_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= (divisor == '0) ? PW'(1) : divisor;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
        quo_r <= {quo_r[rrts_pkg::DLY_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(rrts_pkg::DLY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== src/rrts_table.sv =====
// ----------------------------------------------------------------------------
// rrts_table: thread table storage
// Status and delay memories with one write and one registered read port.
// Per-slot valid bits make unwritten slots read as their reset value.
// ----------------------------------------------------------------------------
module rrts_table #(
  parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(THREAD_COUNT)-1:0] raddr,
  output rrts_pkg::entry_t              rd_ent,
  input  rrts_pkg::tbl_we_t             we,
  input  logic [$clog2(THREAD_COUNT)-1:0] waddr,
  input  rrts_pkg::entry_t              wdata
);

  localparam int IW = $clog2(THREAD_COUNT);

  rrts_pkg::thr_st_t          stat_mem [THREAD_COUNT];
  logic [rrts_pkg::DLY_W-1:0] dly_mem  [THREAD_COUNT];
  logic [THREAD_COUNT-1:0]    vld_r;

  rrts_pkg::thr_st_t          stat_q_r;
  logic [rrts_pkg::DLY_W-1:0] dly_q_r;
  logic                       vld_q_r;
  logic                       zero_q_r;

  // memory write port
  always_ff @(posedge clk) begin
    if (we.stat_we) stat_mem[waddr] <= wdata.st;
    if (we.dly_we)  dly_mem[waddr]  <= wdata.dly;
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      stat_q_r <= stat_mem[raddr];
      dly_q_r  <= dly_mem[raddr];
      vld_q_r  <= vld_r[raddr];
      zero_q_r <= (raddr == IW'(0));
    end
  end

  // slot written in both fields since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we.stat_we && we.dly_we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // unwritten slot: thread 0 running, others unused, no delay
  always_comb begin
    if (vld_q_r) begin
      rd_ent.st  = stat_q_r;
      rd_ent.dly = dly_q_r;
    end else begin
      rd_ent.st  = zero_q_r ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
      rd_ent.dly = '0;
    end
  end

endmodule

// ===== bench/round_robin_thread_scheduler_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core_test: self-checking bench for the
// round-robin thread scheduler
// A queue of scheduler events feeds a driver that presents one request at a
// time. A monitor keeps a software copy of the thread table, predicts the
// result of every accepted request and compares each returned result field by
// field. Eight phases step through tick periods (zero, one, the top of the
// register and values in between) and both scheduling modes. They also step
// through four handshake patterns: none, sender gaps, receiver stalls, and both.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core_test;

  localparam int SLOTS = rrts_pkg::THREAD_COUNT_DEF;
  localparam int PHASES = 8;
  localparam int RAND_PER_PHASE = 228;
  localparam logic [rrts_pkg::KIND_W-1:0] K_UNKNOWN = 3'd7;

  // register map
  localparam logic [2:0] ADDR_TICK_PERIOD = 3'd0;
  localparam logic [2:0] ADDR_PREEMPT     = 3'd4;

  // per-phase register settings; phase 0 runs with the reset values
  localparam int PERIOD_SET [PHASES] = '{10, 1, 1000, 0, 1023, 37, 1, 250};
  localparam int PREEMPT_SET [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};

  typedef struct packed {
    logic [rrts_pkg::KIND_W-1:0] kind;
    logic [rrts_pkg::DLY_W-1:0]  dms;
    logic [rrts_pkg::TID_W-1:0]  tid;
  } sched_req_t;

  typedef struct packed {
    rrts_pkg::res_t            status;
    logic [rrts_pkg::ID_W-1:0] running;
    logic [rrts_pkg::NR_W-1:0] not_ready;
    logic [rrts_pkg::ID_W-1:0] created;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [rrts_pkg::KIND_W-1:0] in_kind = '0;
  logic [rrts_pkg::DLY_W-1:0]  in_delay_ms = '0;
  logic [rrts_pkg::TID_W-1:0]  in_target_id = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [rrts_pkg::STAT_W-1:0] out_status;
  logic [rrts_pkg::ID_W-1:0]   out_running_id;
  logic [rrts_pkg::NR_W-1:0]   out_not_ready_count;
  logic [rrts_pkg::ID_W-1:0]   out_created_id;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench state
  sched_req_t    event_q [$];
  sched_result_t result_q [$];
  int unsigned   issued_cnt = 0;
  int unsigned   presented_cnt = 0;
  int unsigned   accepted_cnt = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   mismatches = 0;
  int unsigned   checked_cnt = 0;
  int unsigned   switch_cnt = 0;
  int unsigned   no_run_cnt = 0;
  int unsigned   full_cnt = 0;
  int unsigned   ignored_cnt = 0;

  // predicted thread table and registers
  rrts_pkg::thr_st_t             slot_state [SLOTS];
  logic [rrts_pkg::DLY_W-1:0]    slot_wait [SLOTS];
  int unsigned                   cur_slot;
  logic [rrts_pkg::PERIOD_W-1:0] tick_period;
  logic                          preempt;

  round_robin_thread_scheduler_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_delay_ms         (in_delay_ms),
    .in_target_id        (in_target_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_running_id      (out_running_id),
    .out_not_ready_count (out_not_ready_count),
    .out_created_id      (out_created_id),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // blocked slots with time left count down; reaching zero makes them ready
  function automatic void count_down_waits();
    int unsigned i;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_state[i] == rrts_pkg::ST_BLOCKED && slot_wait[i] != 0) begin
        slot_wait[i] = slot_wait[i] - 1'b1;
        if (slot_wait[i] == 0) begin
          slot_state[i] = rrts_pkg::ST_READY;
        end
      end
    end
  endfunction

  // round-robin search for the next ready slot after the current one
  function automatic rrts_pkg::res_t search_next(output logic [rrts_pkg::NR_W-1:0] nr);
    int unsigned k;
    int unsigned idx;
    int unsigned hit;
    int unsigned seen;
    hit = SLOTS;
    seen = 0;
    nr = '0;
    for (k = 0; k < SLOTS; k++) begin
      idx = (cur_slot + k) % SLOTS;
      if (slot_state[idx] == rrts_pkg::ST_BLOCKED ||
          slot_state[idx] == rrts_pkg::ST_SUSPENDED) begin
        seen++;
      end
      if (k != 0 && hit == SLOTS && slot_state[idx] == rrts_pkg::ST_READY) begin
        hit = idx;
      end
    end
    if (hit == SLOTS) begin
      nr = seen[rrts_pkg::NR_W-1:0];
      return rrts_pkg::RS_NONE;
    end
    if (slot_state[cur_slot] == rrts_pkg::ST_RUNNING) begin
      slot_state[cur_slot] = rrts_pkg::ST_READY;
    end
    slot_state[hit] = rrts_pkg::ST_RUNNING;
    cur_slot = hit;
    return rrts_pkg::RS_SWITCHED;
  endfunction

  // cooperative mode advances delays on every yield-type event
  function automatic rrts_pkg::res_t yield_step(output logic [rrts_pkg::NR_W-1:0] nr);
    if (!preempt) begin
      count_down_waits();
    end
    return search_next(nr);
  endfunction

  // apply one scheduler event to the predicted table, return its result
  function automatic sched_result_t apply_event(input logic [rrts_pkg::KIND_W-1:0] kind,
                                                input logic [rrts_pkg::DLY_W-1:0] dms,
                                                input logic [rrts_pkg::TID_W-1:0] tid);
    sched_result_t             res;
    logic [rrts_pkg::NR_W-1:0] nr;
    int unsigned               ticks;
    int unsigned               i;
    res.status = rrts_pkg::RS_IGNORED;
    res.created = '0;
    nr = '0;
    case (kind)
      rrts_pkg::K_TICK: begin
        count_down_waits();
        res.status = search_next(nr);
      end
      rrts_pkg::K_YIELD: begin
        res.status = yield_step(nr);
      end
      rrts_pkg::K_CREATE: begin
        res.status = rrts_pkg::RS_FULL;
        for (i = 0; i < SLOTS; i++) begin
          if (res.status == rrts_pkg::RS_FULL && slot_state[i] == rrts_pkg::ST_UNUSED) begin
            slot_state[i] = rrts_pkg::ST_READY;
            slot_wait[i] = '0;
            res.created = i[rrts_pkg::ID_W-1:0];
            res.status = rrts_pkg::RS_DONE;
          end
        end
      end
      rrts_pkg::K_STOP: begin
        if (cur_slot != 0) begin
          slot_state[cur_slot] = rrts_pkg::ST_UNUSED;
          res.status = yield_step(nr);
        end
      end
      rrts_pkg::K_DELAY: begin
        if (dms != 0) begin
          ticks = dms / ((tick_period == 0) ? 1 : tick_period);
          if (ticks == 0) ticks = 1;
          if (ticks > 65535) ticks = 65535;
          slot_wait[cur_slot] = ticks[rrts_pkg::DLY_W-1:0];
          slot_state[cur_slot] = rrts_pkg::ST_BLOCKED;
          res.status = yield_step(nr);
        end
      end
      rrts_pkg::K_SUSPEND: begin
        slot_state[cur_slot] = rrts_pkg::ST_SUSPENDED;
        res.status = yield_step(nr);
      end
      rrts_pkg::K_RESUME: begin
        if (tid < SLOTS && slot_state[tid] == rrts_pkg::ST_SUSPENDED) begin
          slot_state[tid] = rrts_pkg::ST_READY;
          res.status = rrts_pkg::RS_DONE;
        end
      end
      default: ;
    endcase
    res.not_ready = nr;
    res.running = cur_slot[rrts_pkg::ID_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // driver: new request or idle once the previous one was taken
  always @(negedge clk) begin : drive
    sched_req_t nxt;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (accepted_cnt == presented_cnt) begin
        if (event_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = event_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_delay_ms <= nxt.dms;
          in_target_id <= nxt.tid;
          presented_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check returned results, predict accepted requests
  always @(posedge clk) begin : monitor
    sched_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result returned with no request outstanding: status %0d",
                 out_status);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("running_id", want.running, out_running_id);
          check_field("not_ready_count", want.not_ready, out_not_ready_count);
          check_field("created_id", want.created, out_created_id);
          checked_cnt++;
          case (want.status)
            rrts_pkg::RS_SWITCHED: switch_cnt++;
            rrts_pkg::RS_NONE:     no_run_cnt++;
            rrts_pkg::RS_FULL:     full_cnt++;
            rrts_pkg::RS_IGNORED:  ignored_cnt++;
            default: ;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(apply_event(in_kind, in_delay_ms, in_target_id));
        accepted_cnt++;
      end
    end
  end

  task automatic queue_event(input logic [rrts_pkg::KIND_W-1:0] kind, input int unsigned dms,
                             input int unsigned tid);
    sched_req_t req;
    req.kind = kind;
    req.dms = dms[rrts_pkg::DLY_W-1:0];
    req.tid = tid[rrts_pkg::TID_W-1:0];
    event_q.push_back(req);
    issued_cnt++;
  endtask

  // APB write: setup, then access until pready
  task automatic write_reg(input logic [2:0] addr, input int unsigned data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TICK_PERIOD) tick_period = data[rrts_pkg::PERIOD_W-1:0];
    else if (addr == ADDR_PREEMPT) preempt = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned r;
    int unsigned div;
    int unsigned dms;
    int unsigned tid;
    logic [rrts_pkg::KIND_W-1:0] kind;
    for (n = 0; n < SLOTS; n++) begin
      slot_state[n] = rrts_pkg::ST_UNUSED;
      slot_wait[n] = '0;
    end
    slot_state[0] = rrts_pkg::ST_RUNNING;
    cur_slot = 0;
    tick_period = 10'd10;
    preempt = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        write_reg(ADDR_TICK_PERIOD, PERIOD_SET[ph]);
        write_reg(ADDR_PREEMPT, PREEMPT_SET[ph]);
      end
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 74; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 74; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase

      if (ph == 0) begin
        // lone thread: searches fail, the ignored cases
        queue_event(rrts_pkg::K_YIELD, 0, 0);
        queue_event(rrts_pkg::K_TICK, 0, 0);
        queue_event(K_UNKNOWN, 16'hffff, 4'hf);
        queue_event(rrts_pkg::K_STOP, 0, 0);
        queue_event(rrts_pkg::K_DELAY, 0, 0);
        queue_event(rrts_pkg::K_RESUME, 0, 15);
        queue_event(rrts_pkg::K_RESUME, 0, 2);
        // fill the table, then one create too many
        repeat (SLOTS - 1) queue_event(rrts_pkg::K_CREATE, 0, 0);
        queue_event(rrts_pkg::K_CREATE, 0, 0);
        queue_event(rrts_pkg::K_YIELD, 0, 0);
        // longest delay, then a delay below one tick
        queue_event(rrts_pkg::K_DELAY, 65535, 0);
        queue_event(rrts_pkg::K_DELAY, 5, 0);
        queue_event(rrts_pkg::K_SUSPEND, 0, 8);
        queue_event(rrts_pkg::K_RESUME, 0, 3);
        queue_event(rrts_pkg::K_STOP, 0, 0);
        queue_event(rrts_pkg::K_TICK, 0, 0);
        queue_event(rrts_pkg::K_SUSPEND, 0, 0);
      end

      div = (PERIOD_SET[ph] == 0) ? 1 : PERIOD_SET[ph];
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 24) kind = rrts_pkg::K_TICK;
        else if (r < 38) kind = rrts_pkg::K_YIELD;
        else if (r < 52) kind = rrts_pkg::K_CREATE;
        else if (r < 60) kind = rrts_pkg::K_STOP;
        else if (r < 74) kind = rrts_pkg::K_DELAY;
        else if (r < 83) kind = rrts_pkg::K_SUSPEND;
        else if (r < 98) kind = rrts_pkg::K_RESUME;
        else kind = K_UNKNOWN;
        tid = ($urandom_range(99) < 85) ? $urandom_range(SLOTS - 1) : $urandom_range(15);
        dms = $urandom_range(65535);
        if (kind == rrts_pkg::K_DELAY) begin
          // mostly delays of a few ticks so blocked threads come back;
          // full-range values only where the period keeps them short
          if (div >= 100 && $urandom_range(3) == 0) dms = $urandom_range(65535);
          else if ($urandom_range(19) == 0) dms = 0;
          else dms = $urandom_range(6 * div, 1);
        end
        queue_event(kind, dms, tid);
      end

      while (issued_cnt != accepted_cnt || result_q.size() != 0) @(negedge clk);
    end

    repeat (40) @(posedge clk);
    $display("%0d results checked over %0d phases of register and handshake settings",
             checked_cnt, PHASES);
    $display("switches %0d, failed searches %0d, full table %0d, ignored %0d",
             switch_cnt, no_run_cnt, full_cnt, ignored_cnt);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #1600000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== round_robin_thread_scheduler_core.f =====
src/rrts_pkg.sv
src/rrts_div.sv
src/rrts_table.sv
src/round_robin_thread_scheduler_core.sv
bench/round_robin_thread_scheduler_core_test.sv
